// File: hdl/cdas_pkg.sv
// ----------------------------------------------------------------------------
// cdas_pkg: shared types and constants for the calendar date add/subtract block
// Field widths, Julian day constants, fixed reciprocals for constant division
// and the stage records of the date arithmetic pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdas_pkg;

    localparam int NSTG = 11;

    // request and result field widths
    localparam int YEAR_W = 14;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 16;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;

    // internal widths
    localparam int YT_W   = 23;   // floor(365.25 * year)
    localparam int MT_W   = 9;    // floor(30.6001 * (month + 1))
    localparam int MIDX_W = 5;
    localparam int TOD_W  = 11;   // hour * 60 + minute, up to 1923
    localparam int DAYS_W = 23;   // Julian day number of an operand
    localparam int MINS_W = 34;   // operand in minutes
    localparam int RES_W  = 36;   // signed sum or difference
    localparam int X_W    = 35;   // non-negative result, shifted by half a day unless a span
    localparam int XH_W   = 30;   // X_W without the five bits below 32
    localparam int LO_W   = 5;
    localparam int Q_W    = 24;   // whole days
    localparam int R45_W  = 6;
    localparam int REM_W  = 11;   // minute of the day
    localparam int NUM_W  = 31;   // 100 * (jd + 1537) - 12210
    localparam int C_W    = 16;
    localparam int D_W    = 24;
    localparam int XD_W   = 9;    // day within the year, 123..488
    localparam int E_W    = 5;

    localparam int MIN_PER_DAY = 1440;
    localparam int HALF_DAY    = 720;
    localparam int JD_OFFSET   = 1720981;
    localparam int SPAN_LIMIT  = 500 * MIN_PER_DAY;
    localparam int BB_OFFSET   = 1537;
    localparam int C_BIAS      = 100 * BB_OFFSET - 12210;
    localparam int YEAR_BIAS   = 4715;

    // floor(n / d) = (n * ceil(2^k / d)) >> k, exact for n below 2^(k - ceil(log2 d))
    localparam int RCP45_SH = 36;
    localparam int RCP45_W  = 31;
    localparam logic [RCP45_W-1:0] RCP45 =
        RCP45_W'(((64'd1 << RCP45_SH) + 64'd44) / 64'd45);

    localparam int RCPC_SH = 47;
    localparam int RCPC_W  = 32;
    localparam logic [RCPC_W-1:0] RCPC =
        RCPC_W'(((64'd1 << RCPC_SH) + 64'd36524) / 64'd36525);

    localparam int RCP60_SH = 17;
    localparam int RCP60_W  = 12;
    localparam logic [RCP60_W-1:0] RCP60 =
        RCP60_W'(((64'd1 << RCP60_SH) + 64'd59) / 64'd60);

    // 10000 folded in: e = floor(x * 10000 / 306001)
    localparam int RCPE_SH = 42;
    localparam int RCPE_W  = 38;
    localparam logic [RCPE_W-1:0] RCPE =
        RCPE_W'(64'd10000 * (((64'd1 << RCPE_SH) + 64'd306000) / 64'd306001));

    localparam int PROD45_W = XH_W + RCP45_W;
    localparam int PRODC_W  = NUM_W + RCPC_W;
    localparam int PROD60_W = REM_W + RCP60_W;
    localparam int PRODE_W  = XD_W + RCPE_W;

    typedef struct packed {
        logic              cal;
        logic [YT_W-1:0]   yterm;
        logic [MT_W-1:0]   mterm;
        logic [DAY_W-1:0]  day;
        logic [TOD_W-1:0]  tod;
    } opnd_a_t;

    typedef struct packed {
        logic              cal;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } opnd_b_t;

    typedef struct packed {
        logic           sub;
        opnd_a_t [1:0]  op;
    } s1_t;

    typedef struct packed {
        logic           sub;
        opnd_b_t [1:0]  op;
    } s2_t;

    typedef struct packed {
        logic                    sub;
        logic [1:0][MINS_W-1:0]  mins;
    } s3_t;

    typedef struct packed {
        logic [RES_W-1:0] res;
    } s4_t;

    typedef struct packed {
        logic            neg;
        logic            span;
        logic [X_W-1:0]  x;
    } s5_t;

    typedef struct packed {
        logic                 neg;
        logic                 span;
        logic [XH_W-1:0]      xh;
        logic [LO_W-1:0]      lo;
        logic [PROD45_W-1:0]  prod;
    } s6_t;

    typedef struct packed {
        logic               neg;
        logic               span;
        logic [Q_W-1:0]     q;
        logic [REM_W-1:0]   rem;
        logic [NUM_W-1:0]   num;
    } s7_t;

    typedef struct packed {
        logic                 neg;
        logic                 span;
        logic [Q_W-1:0]       q;
        logic [REM_W-1:0]     rem;
        logic [PRODC_W-1:0]   pc;
        logic [PROD60_W-1:0]  ph;
    } s8_t;

    typedef struct packed {
        logic               neg;
        logic               span;
        logic [Q_W-1:0]     q;
        logic [C_W-1:0]     c;
        logic [HOUR_W-1:0]  hr;
        logic [MIN_W-1:0]   mi;
        logic [XD_W-1:0]    x;
    } s9_t;

    typedef struct packed {
        logic                neg;
        logic                span;
        logic [Q_W-1:0]      q;
        logic [C_W-1:0]      yb;
        logic [HOUR_W-1:0]   hr;
        logic [MIN_W-1:0]    mi;
        logic [XD_W-1:0]     x;
        logic [PRODE_W-1:0]  pe;
    } s10_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MON_W-1:0]   month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic               dur;
        logic               neg;
    } res_t;

    // floor(30.6001 * k)
    function automatic logic [MT_W-1:0] month_span(input logic [MIDX_W-1:0] k);
        logic [MT_W-1:0] v;
        case (k)
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/calendar_date_add_subtract.sv
// ----------------------------------------------------------------------------
// calendar_date_add_subtract: add or subtract two date-times
// Each operand (year, month, day, hour, minute) is a calendar date-time valid
// from 1900 to 2099, or a span of days, hours and minutes when its year is 0.
// opcode 0 adds the second operand to the first, opcode 1 subtracts it. The
// result comes back as a calendar date, or as a span when it is below 500 days;
// a negative result gives is_negative and is_duration with all fields zero.
// All arithmetic is in exact integer minutes. The block is an 11-stage
// pipeline that takes one request every clock cycle while in_stall is low; a
// result passes through the stage registers s1 to s11 in order. Every stage holds
// constant multipliers, adds or compares, and a stalled output lets bubbles in
// the pipeline close up, so requests keep flowing until all stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_add_subtract (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [cdas_pkg::YEAR_W-1:0]  first_year,
    input  logic [cdas_pkg::MON_W-1:0]   first_month,
    input  logic [cdas_pkg::DAY_W-1:0]   first_day,
    input  logic [cdas_pkg::HOUR_W-1:0]  first_hour,
    input  logic [cdas_pkg::MIN_W-1:0]   first_minute,
    input  logic                         opcode,
    input  logic [cdas_pkg::YEAR_W-1:0]  second_year,
    input  logic [cdas_pkg::MON_W-1:0]   second_month,
    input  logic [cdas_pkg::DAY_W-1:0]   second_day,
    input  logic [cdas_pkg::HOUR_W-1:0]  second_hour,
    input  logic [cdas_pkg::MIN_W-1:0]   second_minute,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cdas_pkg::YEAR_W-1:0]  out_year,
    output logic [cdas_pkg::MON_W-1:0]   out_month,
    output logic [cdas_pkg::DAY_W-1:0]   out_day,
    output logic [cdas_pkg::HOUR_W-1:0]  out_hour,
    output logic [cdas_pkg::MIN_W-1:0]   out_minute,
    output logic                         is_duration,
    output logic                         is_negative
);

    import cdas_pkg::*;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] vld_next;
    logic [NSTG:1] adv;

    s1_t  s1_reg,  s1_next;
    s2_t  s2_reg,  s2_next;
    s3_t  s3_reg,  s3_next;
    s4_t  s4_reg,  s4_next;
    s5_t  s5_reg,  s5_next;
    s6_t  s6_reg,  s6_next;
    s7_t  s7_reg,  s7_next;
    s8_t  s8_reg,  s8_next;
    s9_t  s9_reg,  s9_next;
    s10_t s10_reg, s10_next;
    res_t s11_reg, s11_next;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    assign adv[NSTG] = !vld_reg[NSTG] || !out_stall;

    for (genvar i = 1; i < NSTG; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign in_stall = !adv[1];

    always_comb
    begin
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NSTG; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: year and month terms, time of day
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [YEAR_W-1:0]   yr;
        logic [MON_W-1:0]    mo;
        logic [DAY_W-1:0]    dy;
        logic [HOUR_W-1:0]   hr;
        logic [MIN_W-1:0]    mi;
        logic                low;
        logic [YEAR_W-1:0]   yadj;
        logic [MIDX_W-1:0]   madj;
        logic [YT_W+1:0]     yprod;
        s1_next.sub = opcode;
        for (int k = 0; k < 2; k++)
        begin
            yr = (k == 0) ? first_year   : second_year;
            mo = (k == 0) ? first_month  : second_month;
            dy = (k == 0) ? first_day    : second_day;
            hr = (k == 0) ? first_hour   : second_hour;
            mi = (k == 0) ? first_minute : second_minute;
            // January and February count as months 13 and 14 of the year before
            low  = (mo <= MON_W'(2));
            yadj = low ? (yr - YEAR_W'(1)) : yr;
            madj = low ? (MIDX_W'(mo) + MIDX_W'(12)) : MIDX_W'(mo);
            yprod = (YT_W+2)'(yadj) * (YT_W+2)'(1461);
            s1_next.op[k].cal   = (yr != '0);
            s1_next.op[k].yterm = (yr != '0) ? yprod[YT_W+1:2] : '0;
            s1_next.op[k].mterm = (yr != '0) ? month_span(madj + MIDX_W'(1)) : '0;
            s1_next.op[k].day   = dy;
            s1_next.op[k].tod   = TOD_W'(hr) * TOD_W'(60) + TOD_W'(mi);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: day number
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_next.sub = s1_reg.sub;
        for (int k = 0; k < 2; k++)
        begin
            s2_next.op[k].cal = s1_reg.op[k].cal;
            s2_next.op[k].tod = s1_reg.op[k].tod;
            if (s1_reg.op[k].cal)
            begin
                s2_next.op[k].days = DAYS_W'(s1_reg.op[k].yterm)
                                   + DAYS_W'(s1_reg.op[k].mterm)
                                   + DAYS_W'(s1_reg.op[k].day)
                                   + DAYS_W'(JD_OFFSET);
            end
            else
            begin
                s2_next.op[k].days = DAYS_W'(s1_reg.op[k].day);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: minutes; a calendar day starts half a Julian day in
    // ------------------------------------------------------------------
    always_comb
    begin
        s3_next.sub = s2_reg.sub;
        for (int k = 0; k < 2; k++)
        begin
            s3_next.mins[k] = MINS_W'(s2_reg.op[k].days) * MINS_W'(MIN_PER_DAY)
                            + (s2_reg.op[k].cal ? MINS_W'(HALF_DAY) : '0)
                            + MINS_W'(s2_reg.op[k].tod);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add or subtract
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s3_reg.sub)
        begin
            s4_next.res = RES_W'(s3_reg.mins[0]) - RES_W'(s3_reg.mins[1]);
        end
        else
        begin
            s4_next.res = RES_W'(s3_reg.mins[0]) + RES_W'(s3_reg.mins[1]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: classify; shift a calendar result back to Julian day start
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [X_W-1:0] mag;
        mag          = s4_reg.res[X_W-1:0];
        s5_next.neg  = s4_reg.res[RES_W-1];
        s5_next.span = !s4_reg.res[RES_W-1] && (mag < X_W'(SPAN_LIMIT));
        s5_next.x    = s5_next.span ? mag : (mag + X_W'(HALF_DAY));
    end

    // ------------------------------------------------------------------
    // Stage 6: divide by 1440 = 32 * 45, reciprocal product for the 45
    // ------------------------------------------------------------------
    always_comb
    begin
        s6_next.neg  = s5_reg.neg;
        s6_next.span = s5_reg.span;
        s6_next.xh   = s5_reg.x[X_W-1:LO_W];
        s6_next.lo   = s5_reg.x[LO_W-1:0];
        s6_next.prod = PROD45_W'(s5_reg.x[X_W-1:LO_W]) * PROD45_W'(RCP45);
    end

    // ------------------------------------------------------------------
    // Stage 7: whole days, minute of day, numerator of the century term
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [Q_W-1:0]  q;
        logic [XH_W-1:0] r45;
        q   = s6_reg.prod[RCP45_SH +: Q_W];
        r45 = s6_reg.xh - XH_W'(q) * XH_W'(45);
        s7_next.neg  = s6_reg.neg;
        s7_next.span = s6_reg.span;
        s7_next.q    = q;
        s7_next.rem  = {r45[R45_W-1:0], s6_reg.lo};
        s7_next.num  = NUM_W'(q) * NUM_W'(100) + NUM_W'(C_BIAS);
    end

    // ------------------------------------------------------------------
    // Stage 8: reciprocal products for / 36525 and / 60
    // ------------------------------------------------------------------
    always_comb
    begin
        s8_next.neg  = s7_reg.neg;
        s8_next.span = s7_reg.span;
        s8_next.q    = s7_reg.q;
        s8_next.rem  = s7_reg.rem;
        s8_next.pc   = PRODC_W'(s7_reg.num) * PRODC_W'(RCPC);
        s8_next.ph   = PROD60_W'(s7_reg.rem) * PROD60_W'(RCP60);
    end

    // ------------------------------------------------------------------
    // Stage 9: hour and minute; day within the year of the 4-year cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [C_W-1:0]    c;
        logic [HOUR_W-1:0] hr;
        logic [REM_W-1:0]  mrem;
        logic [D_W+1:0]    dprod;
        logic [D_W-1:0]    bb;
        logic [D_W-1:0]    diff;
        c     = s8_reg.pc[RCPC_SH +: C_W];
        hr    = s8_reg.ph[RCP60_SH +: HOUR_W];
        mrem  = s8_reg.rem - REM_W'(hr) * REM_W'(60);
        dprod = (D_W+2)'(c) * (D_W+2)'(1461);
        bb    = s8_reg.q + D_W'(BB_OFFSET);
        diff  = bb - dprod[D_W+1:2];
        s9_next.neg  = s8_reg.neg;
        s9_next.span = s8_reg.span;
        s9_next.q    = s8_reg.q;
        s9_next.c    = c;
        s9_next.hr   = hr;
        s9_next.mi   = mrem[MIN_W-1:0];
        s9_next.x    = diff[XD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 10: month index product, year bias
    // ------------------------------------------------------------------
    always_comb
    begin
        s10_next.neg  = s9_reg.neg;
        s10_next.span = s9_reg.span;
        s10_next.q    = s9_reg.q;
        s10_next.yb   = s9_reg.c - C_W'(YEAR_BIAS);
        s10_next.hr   = s9_reg.hr;
        s10_next.mi   = s9_reg.mi;
        s10_next.x    = s9_reg.x;
        s10_next.pe   = PRODE_W'(s9_reg.x) * PRODE_W'(RCPE);
    end

    // ------------------------------------------------------------------
    // Stage 11: calendar fields and result select
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [E_W-1:0]   e;
        logic [MON_W-1:0] mon;
        logic [XD_W-1:0]  dom;
        logic [C_W-1:0]   yfull;
        e     = s10_reg.pe[RCPE_SH +: E_W];
        mon   = (e >= E_W'(14)) ? MON_W'(e - E_W'(13)) : MON_W'(e - E_W'(1));
        dom   = s10_reg.x - month_span(e);
        yfull = s10_reg.yb - C_W'(mon >= MON_W'(3));
        if (s10_reg.neg)
        begin
            s11_next = '{year: '0, month: '0, day: '0, hour: '0, minute: '0,
                         dur: 1'b1, neg: 1'b1};
        end
        else if (s10_reg.span)
        begin
            s11_next = '{year: '0, month: '0, day: DAY_W'(s10_reg.q),
                         hour: s10_reg.hr, minute: s10_reg.mi,
                         dur: 1'b1, neg: 1'b0};
        end
        else
        begin
            s11_next = '{year: yfull[YEAR_W-1:0], month: mon, day: DAY_W'(dom),
                         hour: s10_reg.hr, minute: s10_reg.mi,
                         dur: 1'b0, neg: 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_reg <= s1_next;
        end
        if (adv[2])
        begin
            s2_reg <= s2_next;
        end
        if (adv[3])
        begin
            s3_reg <= s3_next;
        end
        if (adv[4])
        begin
            s4_reg <= s4_next;
        end
        if (adv[5])
        begin
            s5_reg <= s5_next;
        end
        if (adv[6])
        begin
            s6_reg <= s6_next;
        end
        if (adv[7])
        begin
            s7_reg <= s7_next;
        end
        if (adv[8])
        begin
            s8_reg <= s8_next;
        end
        if (adv[9])
        begin
            s9_reg <= s9_next;
        end
        if (adv[10])
        begin
            s10_reg <= s10_next;
        end
        if (adv[11])
        begin
            s11_reg <= s11_next;
        end
    end

    assign out_valid   = vld_reg[NSTG];
    assign out_year    = s11_reg.year;
    assign out_month   = s11_reg.month;
    assign out_day     = s11_reg.day;
    assign out_hour    = s11_reg.hour;
    assign out_minute  = s11_reg.minute;
    assign is_duration = s11_reg.dur;
    assign is_negative = s11_reg.neg;

`ifndef NO_ASSERTIONS
    // the input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (vld_reg == '1)))
        else $error("input stalled with room in the pipeline");

    a_neg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_negative) |-> (is_duration && out_year == '0 &&
            out_month == '0 && out_day == '0 && out_hour == '0 && out_minute == '0))
        else $error("negative result not cleared");

    a_cal_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_duration) |-> (out_month >= MON_W'(1) &&
            out_month <= MON_W'(12) && out_hour < HOUR_W'(24) && out_minute < MIN_W'(60)))
        else $error("calendar result field out of range");

    a_span_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_duration && !is_negative) |-> (out_year == '0 &&
            out_month == '0 && out_day < DAY_W'(500) && out_hour < HOUR_W'(24) &&
            out_minute < MIN_W'(60)))
        else $error("span result field out of range");
`endif

endmodule

// File: bench/date_sum_checker.sv
// ----------------------------------------------------------------------------
// date_sum_checker: result checker for the calendar date add/subtract block
// Watches both channels. Every accepted request is turned into the expected
// date or span in exact integer minutes and queued. Every accepted result is
// compared field by field against the oldest queued expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_sum_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [cdas_pkg::YEAR_W-1:0]  first_year,
    input  logic [cdas_pkg::MON_W-1:0]   first_month,
    input  logic [cdas_pkg::DAY_W-1:0]   first_day,
    input  logic [cdas_pkg::HOUR_W-1:0]  first_hour,
    input  logic [cdas_pkg::MIN_W-1:0]   first_minute,
    input  logic                         opcode,
    input  logic [cdas_pkg::YEAR_W-1:0]  second_year,
    input  logic [cdas_pkg::MON_W-1:0]   second_month,
    input  logic [cdas_pkg::DAY_W-1:0]   second_day,
    input  logic [cdas_pkg::HOUR_W-1:0]  second_hour,
    input  logic [cdas_pkg::MIN_W-1:0]   second_minute,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [cdas_pkg::YEAR_W-1:0]  out_year,
    input  logic [cdas_pkg::MON_W-1:0]   out_month,
    input  logic [cdas_pkg::DAY_W-1:0]   out_day,
    input  logic [cdas_pkg::HOUR_W-1:0]  out_hour,
    input  logic [cdas_pkg::MIN_W-1:0]   out_minute,
    input  logic                         is_duration,
    input  logic                         is_negative,
    output int                           errors,
    output int                           pending
);

    import cdas_pkg::*;

    localparam longint DAY_MINUTES = 1440;
    localparam longint NOON_SHIFT  = 720;
    localparam longint JULIAN_BASE = 1720981;
    localparam longint SPAN_DAYS   = 500;

    res_t due_results[$];
    int   fail_count = 0;
    int   waiting = 0;

    assign errors  = fail_count;
    assign pending = waiting;

    // A year of zero is a plain span; otherwise a Julian day counted from noon.
    function automatic longint stamp_minutes(input logic [YEAR_W-1:0] yr,
                                             input logic [MON_W-1:0]  mo,
                                             input logic [DAY_W-1:0]  dy,
                                             input logic [HOUR_W-1:0] hr,
                                             input logic [MIN_W-1:0]  mi);
        longint y, m, d, h, n, days;
        y = yr;
        m = mo;
        d = dy;
        h = hr;
        n = mi;
        if (y == 0)
            return d * DAY_MINUTES + h * 60 + n;
        // January and February count as months 13 and 14 of the year before
        if (m <= 2) begin
            y = y - 1;
            m = m + 12;
        end
        days = (y * 1461) / 4 + ((m + 1) * 306001) / 10000 + d + JULIAN_BASE;
        return days * DAY_MINUTES + NOON_SHIFT + h * 60 + n;
    endfunction

    function automatic res_t minutes_to_result(input longint total);
        res_t   r;
        longint shifted, jd, tod, bb, c, d, e, dd, mon, yr;
        r = '0;
        if (total < 0) begin
            r.neg = 1'b1;
            r.dur = 1'b1;
        end else if (total < SPAN_DAYS * DAY_MINUTES) begin
            r.dur    = 1'b1;
            r.day    = DAY_W'(total / DAY_MINUTES);
            r.hour   = HOUR_W'((total % DAY_MINUTES) / 60);
            r.minute = MIN_W'(total % 60);
        end else begin
            shifted = total + NOON_SHIFT;
            jd  = shifted / DAY_MINUTES;
            tod = shifted % DAY_MINUTES;
            bb  = jd + 1537;
            c   = (100 * bb - 12210) / 36525;
            d   = (c * 1461) / 4;
            e   = ((bb - d) * 10000) / 306001;
            dd  = bb - d - (306001 * e) / 10000;
            mon = e - 1 - 12 * (e / 14);
            yr  = c - 4715 - (7 + mon) / 10;
            // keep only the low bits of an out-of-range year
            r.year   = YEAR_W'(yr);
            r.month  = MON_W'(mon);
            r.day    = DAY_W'(dd);
            r.hour   = HOUR_W'(tod / 60);
            r.minute = MIN_W'(tod % 60);
        end
        return r;
    endfunction

    task automatic match_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : watch
        res_t   want;
        longint lhs, rhs;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                lhs = stamp_minutes(first_year, first_month, first_day,
                                    first_hour, first_minute);
                rhs = stamp_minutes(second_year, second_month, second_day,
                                    second_hour, second_minute);
                due_results.push_back(minutes_to_result(opcode ? lhs - rhs : lhs + rhs));
            end
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    match_field("out_year", want.year, out_year);
                    match_field("out_month", want.month, out_month);
                    match_field("out_day", want.day, out_day);
                    match_field("out_hour", want.hour, out_hour);
                    match_field("out_minute", want.minute, out_minute);
                    match_field("is_duration", want.dur, is_duration);
                    match_field("is_negative", want.neg, is_negative);
                end
            end
            waiting = due_results.size();
        end
    end

endmodule

// File: bench/calendar_date_add_subtract_test.sv
// ----------------------------------------------------------------------------
// calendar_date_add_subtract_test: testbench for the date add/subtract block
// Sends directed date and span requests covering field extremes, leap days,
// year ends, odd months and times, span limits and negative results, then a
// random mix of dates, spans and raw noise under random source gaps and
// result stalls. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calendar_date_add_subtract_test;

    import cdas_pkg::*;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } stamp_t;

    typedef enum logic {OP_ADD = 1'b0, OP_SUB = 1'b1} date_op_t;

    localparam int DRAIN_CYCLES = 16;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [YEAR_W-1:0] first_year = '0;
    logic [MON_W-1:0]  first_month = '0;
    logic [DAY_W-1:0]  first_day = '0;
    logic [HOUR_W-1:0] first_hour = '0;
    logic [MIN_W-1:0]  first_minute = '0;
    logic              opcode = 1'b0;
    logic [YEAR_W-1:0] second_year = '0;
    logic [MON_W-1:0]  second_month = '0;
    logic [DAY_W-1:0]  second_day = '0;
    logic [HOUR_W-1:0] second_hour = '0;
    logic [MIN_W-1:0]  second_minute = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [YEAR_W-1:0] out_year;
    logic [MON_W-1:0]  out_month;
    logic [DAY_W-1:0]  out_day;
    logic [HOUR_W-1:0] out_hour;
    logic [MIN_W-1:0]  out_minute;
    logic              is_duration;
    logic              is_negative;

    int errors;
    int pending;
    bit steady = 1'b0;
    int stall_left = 0;

    calendar_date_add_subtract uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_year(first_year), .first_month(first_month), .first_day(first_day),
        .first_hour(first_hour), .first_minute(first_minute), .opcode(opcode),
        .second_year(second_year), .second_month(second_month),
        .second_day(second_day), .second_hour(second_hour),
        .second_minute(second_minute),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_year(out_year), .out_month(out_month), .out_day(out_day),
        .out_hour(out_hour), .out_minute(out_minute),
        .is_duration(is_duration), .is_negative(is_negative)
    );

    date_sum_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .first_year(first_year), .first_month(first_month), .first_day(first_day),
        .first_hour(first_hour), .first_minute(first_minute), .opcode(opcode),
        .second_year(second_year), .second_month(second_month),
        .second_day(second_day), .second_hour(second_hour),
        .second_minute(second_minute),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_year(out_year), .out_month(out_month), .out_day(out_day),
        .out_hour(out_hour), .out_minute(out_minute),
        .is_duration(is_duration), .is_negative(is_negative),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** calendar_date_add_subtract: FAILED **");
        $finish;
    end

    // Stall results in short bursts; hold off stalls during the steady stretch.
    always @(negedge clk)
    begin
        if (steady)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(999) < 27)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic stamp_t stamp(int y, int mo, int d, int h, int mi);
        stamp_t s;
        s.year   = YEAR_W'(y);
        s.month  = MON_W'(mo);
        s.day    = DAY_W'(d);
        s.hour   = HOUR_W'(h);
        s.minute = MIN_W'(mi);
        return s;
    endfunction

    function automatic stamp_t rand_date();
        return stamp($urandom_range(1900, 2099), $urandom_range(1, 12),
                     $urandom_range(0, 3) == 0 ? $urandom_range(1, 31) : $urandom_range(1, 28),
                     $urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    // Month is ignored for a span; vary it now and then anyway.
    function automatic stamp_t rand_span(int max_days);
        return stamp(0, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0,
                     $urandom_range(0, max_days), $urandom_range(0, 23),
                     $urandom_range(0, 59));
    endfunction

    // Same or neighboring year, so that a difference often lands in span range.
    function automatic stamp_t near_date(stamp_t base);
        stamp_t s;
        s = rand_date();
        s.year = base.year + YEAR_W'($urandom_range(0, 2)) - YEAR_W'(1);
        return s;
    endfunction

    // Months outside 1..12 and times past the end of the day.
    function automatic stamp_t odd_date();
        stamp_t s;
        s = rand_date();
        if ($urandom_range(0, 1) == 0)
            s.month = $urandom_range(0, 3) == 0 ? MON_W'(0) : MON_W'($urandom_range(13, 15));
        else
        begin
            s.hour   = HOUR_W'($urandom_range(0, 31));
            s.minute = MIN_W'($urandom_range(0, 63));
        end
        return s;
    endfunction

    function automatic stamp_t noise();
        return stamp($urandom_range(0, 16383), $urandom_range(0, 15),
                     $urandom_range(0, 65535), $urandom_range(0, 31),
                     $urandom_range(0, 63));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(stamp_t a, date_op_t op, stamp_t b);
        if (!steady && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        first_year    <= a.year;
        first_month   <= a.month;
        first_day     <= a.day;
        first_hour    <= a.hour;
        first_minute  <= a.minute;
        opcode        <= op;
        second_year   <= b.year;
        second_month  <= b.month;
        second_day    <= b.day;
        second_hour   <= b.hour;
        second_minute <= b.minute;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        stamp_t   a;
        date_op_t op;
        int       pick;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(stamp(2000, 1, 1, 0, 0), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(2000, 2, 28, 23, 59), OP_ADD, stamp(0, 0, 1, 0, 1));
        issue(stamp(1900, 2, 28, 12, 0), OP_ADD, stamp(0, 0, 1, 0, 0));
        issue(stamp(2099, 12, 31, 23, 59), OP_ADD, stamp(0, 0, 0, 0, 1));
        issue(stamp(2024, 3, 1, 0, 0), OP_SUB, stamp(0, 0, 1, 0, 1));
        issue(stamp(2024, 3, 15, 6, 30), OP_SUB, stamp(2024, 3, 15, 6, 30));
        issue(stamp(2024, 3, 15, 6, 30), OP_SUB, stamp(2025, 7, 4, 0, 0));
        issue(stamp(2025, 7, 4, 0, 0), OP_SUB, stamp(2024, 3, 15, 6, 30));
        // last minute below the span limit, then the first one at it
        issue(stamp(0, 0, 499, 23, 59), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(0, 0, 500, 0, 0), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(0, 0, 3, 4, 5), OP_SUB, stamp(0, 0, 3, 4, 6));
        issue(stamp(0, 0, 0, 0, 0), OP_SUB, stamp(0, 0, 0, 0, 0));
        issue(stamp(0, 0, 65535, 31, 63), OP_ADD, stamp(0, 15, 65535, 31, 63));
        issue(stamp(16383, 15, 65535, 31, 63), OP_ADD, stamp(16383, 15, 65535, 31, 63));
        issue(stamp(16383, 15, 65535, 31, 63), OP_SUB, stamp(0, 0, 0, 0, 0));
        issue(stamp(0, 0, 0, 0, 0), OP_SUB, stamp(16383, 15, 65535, 31, 63));
        issue(stamp(2010, 0, 10, 0, 0), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(2010, 13, 10, 0, 0), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(2010, 14, 10, 0, 0), OP_SUB, stamp(0, 0, 0, 0, 0));
        issue(stamp(2010, 15, 10, 0, 0), OP_ADD, stamp(0, 0, 1, 0, 0));
        issue(stamp(2012, 6, 30, 31, 63), OP_ADD, stamp(0, 0, 0, 24, 0));
        issue(stamp(1, 1, 1, 0, 0), OP_ADD, stamp(0, 0, 0, 0, 0));
        issue(stamp(1985, 10, 26, 1, 21), OP_ADD, stamp(1955, 11, 5, 6, 0));

        for (int n = 0; n < 700; n++)
        begin
            steady = (n >= 250 && n < 400);
            pick = $urandom_range(99);
            op = date_op_t'($urandom_range(0, 1));
            if (pick < 30)
            begin
                issue(rand_date(), op, rand_span(1200));
            end
            else if (pick < 52)
            begin
                a = rand_date();
                issue(a, $urandom_range(0, 4) == 0 ? OP_ADD : OP_SUB, near_date(a));
            end
            else if (pick < 67)
            begin
                issue(rand_span(700), op, rand_span(700));
            end
            else if (pick < 75)
            begin
                issue(rand_date(), op, rand_date());
            end
            else if (pick < 88)
            begin
                issue(odd_date(), op, $urandom_range(0, 1) ? rand_span(40) : odd_date());
            end
            else
            begin
                issue(noise(), op, noise());
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("** calendar_date_add_subtract: PASSED **");
        else
            $display("** calendar_date_add_subtract: FAILED **");
        $finish;
    end

endmodule
